// ===== hw/rtl/pump_stroke_tracker_core_assert.svh =====
// ----------------------------------------------------------------------------
// Pump stroke tracker assertion macros
// Concurrent assertion shorthands used by the tracker core.
// ----------------------------------------------------------------------------
`ifndef PUMP_STROKE_TRACKER_CORE_ASSERT_SVH
`define PUMP_STROKE_TRACKER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PST_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pump stroke tracker: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define PST_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pump stroke tracker: next-cycle check failed");

`endif

// ===== hw/rtl/pst_pkg.sv =====
// ----------------------------------------------------------------------------
// Pump stroke tracker package
// Types, widths, codes and reset values shared by the tracker RTL.
// ----------------------------------------------------------------------------
package pst_pkg;

  localparam int AngleW      = 16;
  localparam int BandW       = 15;
  localparam int StillW      = 16;
  localparam int StrokeW     = 16;
  localparam int LiftW       = 32;
  localparam int SampleW     = 24;
  localparam int CfgIdxW     = 2;
  localparam int CfgDataW    = 16;
  localparam int InDataW     = 40;
  localparam int OutDataW    = 80;
  localparam int OutFieldsW  = 77;
  // Wide enough for any sum or difference of an angle and a span.
  localparam int AngleExtW   = AngleW + 2;

  localparam logic [BandW-1:0]  StillBandRst  = 15'd128;
  localparam logic [StillW-1:0] MaxStillRst   = 16'd100;
  localparam logic [BandW-1:0]  StrokeRangeRst = 15'd1280;

  typedef enum logic {
    CMD_START  = 1'b0,
    CMD_SAMPLE = 1'b1
  } pst_cmd_t;

  typedef enum logic [1:0] {
    STOP_NONE   = 2'd0,
    STOP_WATER  = 2'd1,
    STOP_HANDLE = 2'd2
  } pst_stop_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_STILL_BAND   = 2'd0,
    CFG_MAX_STILL    = 2'd1,
    CFG_STROKE_RANGE = 2'd2
  } pst_cfg_idx_t;

  typedef struct packed {
    logic [BandW-1:0]  still_band;
    logic [StillW-1:0] max_still_samples;
    logic [BandW-1:0]  stroke_range;
  } pst_cfg_t;

  typedef struct packed {
    logic              water_present;
    logic [AngleW-1:0] reference_angle;
    logic [AngleW-1:0] angle;
    pst_cmd_t          command;
  } pst_item_t;

  typedef struct packed {
    logic [AngleW-1:0]  prev_angle;
    logic [AngleW-1:0]  top_angle;
    logic [AngleW-1:0]  bottom_angle;
    logic [StillW-1:0]  still_count;
    logic               stroke_open;
    logic               stroke_closed;
    logic [StrokeW-1:0] strokes;
    logic [LiftW-1:0]   lift_sum;
    logic [SampleW-1:0] samples;
    logic               session_active;
  } pst_state_t;

  // Packed from the lowest bit up: active first.
  typedef struct packed {
    logic [SampleW-1:0] sample_total;
    logic [LiftW-1:0]   lift_total;
    logic [StrokeW-1:0] stroke_total;
    logic               handle_moving;
    pst_stop_t          stop_cause;
    logic               session_done;
    logic               active;
  } pst_result_t;

  localparam pst_state_t StateRst = '{
    prev_angle:     '0,
    top_angle:      '0,
    bottom_angle:   '0,
    still_count:    '0,
    stroke_open:    1'b1,
    stroke_closed:  1'b0,
    strokes:        '0,
    lift_sum:       '0,
    samples:        '0,
    session_active: 1'b0
  };

endpackage

// ===== hw/rtl/pump_stroke_tracker_core.sv =====
// ----------------------------------------------------------------------------
// Pump stroke tracker core
// Follows one hand-pump dispensing session from handle-angle samples.
// ----------------------------------------------------------------------------
// The tracker takes one transaction per clock cycle while the output side is
// ready and returns exactly one result transaction for each. A start
// transaction (tuser 0) opens or restarts a session; sample transactions
// (tuser 1) carry a handle angle and the water sensor flag. Each transaction
// passes an input register, then the compare/add logic against the session
// state, and lands in an output register, from which its result is offered
// and taken when the output side is ready. Sustained rate is one transaction
// per cycle while the output side is ready, set by the state update loop; a
// stalled output holds both registers and drops in_tready only once both are
// full. Totals (strokes, downward lift, sample count) saturate at their
// maximum. Configuration writes take effect on the next edge and must be made
// only while the block is idle.

module pump_stroke_tracker_core (
  input  logic                               clk,
  input  logic                               rst_n,
  // Configuration write port
  input  logic                               cfg_we,
  input  logic [pst_pkg::CfgIdxW-1:0]        cfg_index,
  input  logic [pst_pkg::CfgDataW-1:0]       cfg_wdata,
  // Input stream
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // angle [15:0], reference_angle [31:16], water_present [32], zero [39:33]
  input  logic [pst_pkg::InDataW-1:0]        in_tdata,
  // command [0]
  input  logic                               in_tuser,
  // Result stream
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // active [0], session_done [1], stop_cause [3:2], handle_moving [4],
  // stroke_total [20:5], lift_total [52:21], sample_total [76:53], zero [79:77]
  output logic [pst_pkg::OutDataW-1:0]       out_tdata
);

  `include "pump_stroke_tracker_core_assert.svh"

  pst_pkg::pst_cfg_t    cfg_r;
  pst_pkg::pst_item_t   item_r;
  logic                 item_valid_r;
  pst_pkg::pst_state_t  state_r;
  pst_pkg::pst_state_t  state_nxt;
  pst_pkg::pst_result_t result_nxt;
  pst_pkg::pst_result_t result_r;
  logic                 out_valid_r;
  logic                 advance;
  logic                 step_fire;
  logic                 in_fire;

  // Advance when the output register is empty or being drained this cycle.
  assign advance   = !out_valid_r || out_tready;
  assign step_fire = item_valid_r && advance;
  assign in_tready = !item_valid_r || advance;
  assign in_fire   = in_tvalid && in_tready;

  // Configuration registers; index beyond the list is dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.still_band        <= pst_pkg::StillBandRst;
      cfg_r.max_still_samples <= pst_pkg::MaxStillRst;
      cfg_r.stroke_range      <= pst_pkg::StrokeRangeRst;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pst_pkg::CFG_STILL_BAND:   cfg_r.still_band        <= cfg_wdata[pst_pkg::BandW-1:0];
        pst_pkg::CFG_MAX_STILL:    cfg_r.max_still_samples <= cfg_wdata;
        pst_pkg::CFG_STROKE_RANGE: cfg_r.stroke_range      <= cfg_wdata[pst_pkg::BandW-1:0];
        default: ;
      endcase
    end
  end

  // Input register: load on acceptance, hold while the step stage stalls.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_fire) begin
      item_valid_r <= 1'b1;
    end else if (step_fire) begin
      item_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r.command         <= pst_pkg::pst_cmd_t'(in_tuser);
      item_r.angle           <= in_tdata[15:0];
      item_r.reference_angle <= in_tdata[31:16];
      item_r.water_present   <= in_tdata[32];
    end
  end

  pst_step u_step (
    .cfg       (cfg_r),
    .state     (state_r),
    .item      (item_r),
    .state_nxt (state_nxt),
    .result    (result_nxt)
  );

  // Session state advances exactly when an item moves into the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pst_pkg::StateRst;
    end else if (step_fire) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_fire) begin
      result_r <= result_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(pst_pkg::OutDataW-pst_pkg::OutFieldsW){1'b0}}, result_r};

  // A transaction taken at the input is always held for the step stage.
  `PST_ASSERT_NEXT(a_in_held, in_fire, item_valid_r)
  // A delivered end of session always names its cause.
  `PST_ASSERT_SAME(a_done_cause, out_valid_r && result_r.session_done,
                   result_r.stop_cause != pst_pkg::STOP_NONE && !result_r.active)
  // The session only closes through a result that reports it.
  `PST_ASSERT_SAME(a_close_reported, $past(rst_n) && $fell(state_r.session_active),
                   out_valid_r && result_r.session_done)
  // A stalled output keeps its result.
  `PST_ASSERT_NEXT(a_out_hold, out_valid_r && !out_tready, out_valid_r && $stable(result_r))

endmodule

// ===== hw/rtl/pst_step.sv =====
// ----------------------------------------------------------------------------
// Pump stroke tracker step logic
// Next session state and result fields for one registered item.
// ----------------------------------------------------------------------------
module pst_step (
  input  pst_pkg::pst_cfg_t    cfg,
  input  pst_pkg::pst_state_t  state,
  input  pst_pkg::pst_item_t   item,
  output pst_pkg::pst_state_t  state_nxt,
  output pst_pkg::pst_result_t result
);

  localparam int ExtW = pst_pkg::AngleExtW;

  logic signed [ExtW-1:0] ang_ext;
  logic signed [ExtW-1:0] prev_ext;
  logic signed [ExtW-1:0] delta;
  logic signed [ExtW-1:0] neg_delta;
  logic signed [ExtW-1:0] band_ext;
  logic signed [ExtW-1:0] span_ext;
  logic signed [ExtW-1:0] top_lo;
  logic signed [ExtW-1:0] bot_hi;
  logic                   is_still;
  logic [pst_pkg::StillW-1:0]    still_inc;
  logic [pst_pkg::AngleW:0]      mag;
  logic [pst_pkg::LiftW:0]       lift_ext;
  logic [pst_pkg::StrokeW+1:0]   stroke_ext;
  logic                          cnt_still;
  logic                          cnt_rise;
  logic                          done;
  pst_pkg::pst_stop_t            cause;
  logic                          moving;
  pst_pkg::pst_state_t           nxt;

  // Shared arithmetic on sign-extended angles and zero-extended band and span settings.
  assign ang_ext   = ExtW'($signed(item.angle));
  assign prev_ext  = ExtW'($signed(state.prev_angle));
  assign delta     = ang_ext - prev_ext;
  assign neg_delta = -delta;
  assign band_ext  = $signed({3'b000, cfg.still_band});
  assign span_ext  = $signed({3'b000, cfg.stroke_range});
  assign top_lo    = ExtW'($signed(state.top_angle)) - span_ext;
  assign bot_hi    = ExtW'($signed(state.bottom_angle)) + span_ext;
  assign is_still  = (delta > -band_ext) && (delta < band_ext);
  assign still_inc = (state.still_count != '1) ? state.still_count + 1'b1
                                               : state.still_count;
  assign mag       = neg_delta[pst_pkg::AngleW:0];
  assign lift_ext  = {1'b0, state.lift_sum} + {{(pst_pkg::LiftW-pst_pkg::AngleW){1'b0}}, mag};

  always_comb begin
    nxt        = state;
    done       = 1'b0;
    cause      = pst_pkg::STOP_NONE;
    moving     = 1'b0;
    cnt_still  = 1'b0;
    cnt_rise   = 1'b0;
    stroke_ext = '0;
    if (item.command == pst_pkg::CMD_START) begin
      nxt                = pst_pkg::StateRst;
      nxt.prev_angle     = item.reference_angle;
      nxt.top_angle      = item.angle;
      nxt.bottom_angle   = item.angle;
      nxt.session_active = 1'b1;
    end else if (state.session_active) begin
      if (state.samples != '1) begin
        nxt.samples = state.samples + 1'b1;
      end
      if (!item.water_present) begin
        nxt.session_active = 1'b0;
        done               = 1'b1;
        cause              = pst_pkg::STOP_WATER;
      end else begin
        nxt.prev_angle = item.angle;
        if (is_still) begin
          nxt.still_count = still_inc;
          if (still_inc > cfg.max_still_samples) begin
            nxt.session_active = 1'b0;
            done               = 1'b1;
            cause              = pst_pkg::STOP_HANDLE;
            cnt_still          = state.stroke_open;
          end
        end else begin
          moving          = 1'b1;
          nxt.still_count = '0;
        end
        if (delta < 0) begin
          nxt.lift_sum = lift_ext[pst_pkg::LiftW] ? '1 : lift_ext[pst_pkg::LiftW-1:0];
          if (ang_ext < top_lo && !state.stroke_open) begin
            nxt.stroke_open   = 1'b1;
            nxt.stroke_closed = 1'b0;
            nxt.bottom_angle  = item.angle;
          end
          if ($signed(item.angle) < $signed(nxt.bottom_angle)) begin
            nxt.bottom_angle = item.angle;
          end
        end else if (ang_ext > bot_hi) begin
          if (!state.stroke_closed) begin
            cnt_rise          = 1'b1;
            nxt.stroke_closed = 1'b1;
            nxt.stroke_open   = 1'b0;
            nxt.top_angle     = item.angle;
          end
          if ($signed(item.angle) > $signed(nxt.top_angle)) begin
            nxt.top_angle = item.angle;
          end
        end
      end
      // Both counts saturate independently; summing then clamping is equivalent.
      stroke_ext = {2'b00, state.strokes} + {{pst_pkg::StrokeW{1'b0}}, 1'b0, cnt_still}
                 + {{pst_pkg::StrokeW{1'b0}}, 1'b0, cnt_rise};
      nxt.strokes = (stroke_ext[pst_pkg::StrokeW+1:pst_pkg::StrokeW] != 2'b00)
                  ? '1 : stroke_ext[pst_pkg::StrokeW-1:0];
    end
  end

  assign state_nxt            = nxt;
  assign result.active        = nxt.session_active;
  assign result.session_done  = done;
  assign result.stop_cause    = cause;
  assign result.handle_moving = moving;
  assign result.stroke_total  = nxt.strokes;
  assign result.lift_total    = nxt.lift_sum;
  assign result.sample_total  = nxt.samples;

endmodule
